[rtl/core/assert_macros.svh]
// Assertion macros shared by the weight update core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, held off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/adamw_pkg.sv]
// Types and constants of the AdamW weight update core.
`timescale 1ns / 1ps

package adamw_pkg;

	// Table depth default
	localparam int NUM_WEIGHTS_DEF = 128;

	// Configuration register indexes
	localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
	localparam logic [1:0] REG_WEIGHT_DECAY  = 2'd1;
	localparam logic [1:0] REG_TRAIN_COUNT   = 2'd2;

	// Configuration reset values
	localparam logic [23:0] LR_RESET = 24'd65536;
	localparam logic [15:0] WD_RESET = 16'd0;
	localparam logic [23:0] TC_RESET = 24'd1;

	// Betas and their complements in Q0.32
	localparam logic [31:0] B1_Q32 = 32'd3865470566;
	localparam logic [31:0] C1_Q32 = 32'd429496730;
	localparam logic [31:0] B2_Q32 = 32'd4290672329;
	localparam logic [31:0] C2_Q32 = 32'd4294967;

	// Epsilon in Q8.40 and the step cap (2^34)
	localparam logic [48:0] EPS_Q40  = 49'd10995;
	localparam logic [34:0] STEP_CAP = 35'h4_0000_0000;

	// Sequencer counts: multiply, divide and square root
	localparam logic [6:0] MUL_ISSUE = 7'd4;
	localparam logic [6:0] MUL_DONE  = 7'd5;
	localparam logic [6:0] DIV_LAST  = 7'd64;
	localparam logic [6:0] DIV_DONE  = 7'd65;
	localparam logic [6:0] SQRT_LAST = 7'd48;
	localparam logic [6:0] SQRT_DONE = 7'd49;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_READ,
		ST_DIVG,
		ST_MULM1,
		ST_MULM2,
		ST_MSUM,
		ST_MULGSQ,
		ST_MULV2,
		ST_MULV1,
		ST_VSUM,
		ST_DIVMH,
		ST_DIVVH,
		ST_SQRT,
		ST_DIVRT,
		ST_MULSTEP,
		ST_WSTEP,
		ST_MULDEC,
		ST_WDEC,
		ST_MULB1,
		ST_MULB2,
		ST_WB
	} state_t;

endpackage

[rtl/core/adamw_weight_update.sv]
// AdamW weight update core: moment tables, shared multiplier and divider, sequencer.
//
//  channel   dir  handshake                        beat contents
//  s_axis    in   s_axis_tvalid / s_axis_tready    kind, index, start weight, gradient, last
//  m_axis    out  m_axis_tvalid / m_axis_tready    index, weight Q16.16, rounded, saturated
//  cfg       in   cfg_valid / cfg_ready            register index, write data
//
// A load beat or an out-of-range index passes only the read and write-back states.
// A gradient beat needs one more product with decay and two more at epoch end:
// four 64-step divisions and a 48-step square root share one shift-subtract unit,
// and nine products share one 32x32 multiplier over four partial products each.
// After reset all NUM_WEIGHTS entries of the moment tables are cleared, one entry a cycle.
// A stalled result holds in the output register; the next beat is accepted meanwhile.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adamw_weight_update #(
	parameter int NUM_WEIGHTS = adamw_pkg::NUM_WEIGHTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // param_index[6:0], start_weight[22:7], grad_sum[70:23]
	input  logic        s_axis_tuser,  // kind
	input  logic        s_axis_tlast,  // last_in_epoch
	// result beats
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // out_index[6:0], weight_fixed[38:7], weight_rounded[54:39]
	output logic        m_axis_tuser,  // saturated
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WEIGHTS - 1);

	adamw_pkg::state_t state_q, state_d;
	logic [6:0] cnt_q;

	// configuration and beta powers
	logic [23:0] lr_q, tc_q;
	logic [15:0] wd_q;
	logic [31:0] b1p_q, b2p_q;

	// clearing pass
	logic          clr_q;
	logic [AW-1:0] clr_cnt_q;

	// latched beat
	logic          kind_q, last_q, inr_q;
	logic [6:0]    idx_q;
	logic [15:0]   sw_q;
	logic [47:0]   grad_q;
	logic [AW-1:0] addr_q;

	// tables and read data
	logic [31:0] w_mem [NUM_WEIGHTS];
	logic [15:0] a_mem [NUM_WEIGHTS];
	logic [47:0] m_mem [NUM_WEIGHTS];
	logic [63:0] v_mem [NUM_WEIGHTS];
	logic [31:0] w_rd_q;
	logic [15:0] a_rd_q;
	logic [47:0] m_rd_q;
	logic [63:0] v_rd_q;

	// intermediate values
	logic [47:0] gm_q, m1_q, m2_q, m_new_q;
	logic [63:0] gsq_q, v1_q, v2_q, v_new_q, mhat_q, vhat_q, ratio_q;
	logic [48:0] den_q;
	logic [34:0] step_q;
	logic [33:0] dec_q;
	logic [31:0] w_q;
	logic        sat_q;

	// output register
	logic        m_valid_q;
	logic [6:0]  o_idx_q;
	logic [31:0] o_wf_q;
	logic [15:0] o_wr_q;
	logic        o_sat_q;

	// shared units
	logic [63:0]  mul_a, mul_b, mul_res;
	logic         mul_s16, is_mul, is_div, is_sqrt;
	logic [63:0]  div_hi, div_lo, div_d, div_q;
	logic [63:0]  p_s1;
	logic [1:0]   pk_s1;
	logic [127:0] acc_q, pp_shift;
	logic [31:0]  a_part, b_part;
	logic [63:0]  rem_q, dq_q, d_q;
	logic [47:0]  root_q;
	logic         dsat_q;
	logic [65:0]  shv, opv;
	logic [66:0]  dif;
	logic         ge;

	logic s_acc, wb_go, wb_we, op_done;
	logic [31:0]   in_idx_ext;
	logic [AW-1:0] in_addr;

	// sign magnitudes and combined values
	logic [47:0] m_old_mag, g_in_mag, wm;
	logic [49:0] ms1, ms2, msum;
	logic [64:0] vsum;
	logic [36:0] wext, wt;
	logic [32:0] diff, diff_mag;
	logic [34:0] wext2, wt2;
	logic [32:0] wmag, rsum;
	logic [16:0] rr17;
	logic [15:0] rr;

	assign cfg_ready     = 1'b1;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign in_idx_ext    = 32'(s_axis_tdata[6:0]);
	assign in_addr       = in_idx_ext[AW-1:0];
	assign wb_go         = !m_valid_q || m_axis_tready;
	assign wb_we         = (state_q == adamw_pkg::ST_WB) && wb_go && inr_q;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, o_wr_q, o_wf_q, o_idx_q};
	assign m_axis_tuser  = o_sat_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			adamw_pkg::ST_IDLE:    if (s_acc) state_d = adamw_pkg::ST_READ;
			adamw_pkg::ST_READ:    state_d = (!inr_q || !kind_q) ? adamw_pkg::ST_WB
				: adamw_pkg::ST_DIVG;
			adamw_pkg::ST_DIVG:    if (op_done) state_d = adamw_pkg::ST_MULM1;
			adamw_pkg::ST_MULM1:   if (op_done) state_d = adamw_pkg::ST_MULM2;
			adamw_pkg::ST_MULM2:   if (op_done) state_d = adamw_pkg::ST_MSUM;
			adamw_pkg::ST_MSUM:    state_d = adamw_pkg::ST_MULGSQ;
			adamw_pkg::ST_MULGSQ:  if (op_done) state_d = adamw_pkg::ST_MULV2;
			adamw_pkg::ST_MULV2:   if (op_done) state_d = adamw_pkg::ST_MULV1;
			adamw_pkg::ST_MULV1:   if (op_done) state_d = adamw_pkg::ST_VSUM;
			adamw_pkg::ST_VSUM:    state_d = adamw_pkg::ST_DIVMH;
			adamw_pkg::ST_DIVMH:   if (op_done) state_d = adamw_pkg::ST_DIVVH;
			adamw_pkg::ST_DIVVH:   if (op_done) state_d = adamw_pkg::ST_SQRT;
			adamw_pkg::ST_SQRT:    if (op_done) state_d = adamw_pkg::ST_DIVRT;
			adamw_pkg::ST_DIVRT:   if (op_done) state_d = adamw_pkg::ST_MULSTEP;
			adamw_pkg::ST_MULSTEP: if (op_done) state_d = adamw_pkg::ST_WSTEP;
			adamw_pkg::ST_WSTEP: begin
				if (wd_q != 16'd0) state_d = adamw_pkg::ST_MULDEC;
				else state_d = last_q ? adamw_pkg::ST_MULB1 : adamw_pkg::ST_WB;
			end
			adamw_pkg::ST_MULDEC:  if (op_done) state_d = adamw_pkg::ST_WDEC;
			adamw_pkg::ST_WDEC:    state_d = last_q ? adamw_pkg::ST_MULB1 : adamw_pkg::ST_WB;
			adamw_pkg::ST_MULB1:   if (op_done) state_d = adamw_pkg::ST_MULB2;
			adamw_pkg::ST_MULB2:   if (op_done) state_d = adamw_pkg::ST_WB;
			adamw_pkg::ST_WB:      if (wb_go) state_d = adamw_pkg::ST_IDLE;
			default:               state_d = adamw_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: ready and operand selection for the shared units
	always_comb begin
		s_axis_tready = 1'b0;
		is_mul  = 1'b0;
		is_div  = 1'b0;
		is_sqrt = 1'b0;
		mul_s16 = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		div_hi  = '0;
		div_lo  = '0;
		div_d   = '0;
		unique case (state_q)
			adamw_pkg::ST_IDLE: s_axis_tready = !clr_q;
			adamw_pkg::ST_DIVG: begin
				is_div = 1'b1;
				div_lo = 64'(g_in_mag);
				div_d  = (tc_q == 24'd0) ? 64'd1 : 64'(tc_q);
			end
			adamw_pkg::ST_MULM1: begin
				is_mul = 1'b1;
				mul_a  = 64'(m_old_mag);
				mul_b  = 64'(adamw_pkg::B1_Q32);
			end
			adamw_pkg::ST_MULM2: begin
				is_mul = 1'b1;
				mul_a  = 64'(gm_q);
				mul_b  = 64'(adamw_pkg::C1_Q32);
			end
			adamw_pkg::ST_MULGSQ: begin
				is_mul = 1'b1;
				mul_a  = 64'(gm_q);
				mul_b  = 64'(gm_q);
			end
			adamw_pkg::ST_MULV2: begin
				is_mul = 1'b1;
				mul_a  = gsq_q;
				mul_b  = 64'(adamw_pkg::C2_Q32);
			end
			adamw_pkg::ST_MULV1: begin
				is_mul = 1'b1;
				mul_a  = v_rd_q;
				mul_b  = 64'(adamw_pkg::B2_Q32);
			end
			adamw_pkg::ST_DIVMH: begin
				is_div = 1'b1;
				div_hi = 64'(wm[47:32]);
				div_lo = {wm[31:0], 32'd0};
				div_d  = 64'(33'h1_0000_0000 - {1'b0, b1p_q});
			end
			adamw_pkg::ST_DIVVH: begin
				is_div = 1'b1;
				div_hi = 64'(v_new_q[63:32]);
				div_lo = {v_new_q[31:0], 32'd0};
				div_d  = 64'(33'h1_0000_0000 - {1'b0, b2p_q});
			end
			adamw_pkg::ST_SQRT: is_sqrt = 1'b1;
			adamw_pkg::ST_DIVRT: begin
				is_div = 1'b1;
				div_hi = 64'(mhat_q[63:32]);
				div_lo = {mhat_q[31:0], 32'd0};
				div_d  = 64'(den_q);
			end
			adamw_pkg::ST_MULSTEP: begin
				is_mul = 1'b1;
				mul_a  = ratio_q;
				mul_b  = 64'(lr_q);
			end
			adamw_pkg::ST_MULDEC: begin
				is_mul  = 1'b1;
				mul_s16 = 1'b1;
				mul_a   = 64'(diff_mag);
				mul_b   = 64'(wd_q);
			end
			adamw_pkg::ST_MULB1: begin
				is_mul = 1'b1;
				mul_a  = 64'(b1p_q);
				mul_b  = 64'(adamw_pkg::B1_Q32);
			end
			adamw_pkg::ST_MULB2: begin
				is_mul = 1'b1;
				mul_a  = 64'(b2p_q);
				mul_b  = 64'(adamw_pkg::B2_Q32);
			end
			default: ;
		endcase
		op_done = (is_mul && cnt_q == adamw_pkg::MUL_DONE)
			|| (is_div && cnt_q == adamw_pkg::DIV_DONE)
			|| (is_sqrt && cnt_q == adamw_pkg::SQRT_DONE);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= adamw_pkg::ST_IDLE;
			cnt_q     <= '0;
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			m_valid_q <= 1'b0;
			lr_q      <= adamw_pkg::LR_RESET;
			wd_q      <= adamw_pkg::WD_RESET;
			tc_q      <= adamw_pkg::TC_RESET;
			b1p_q     <= adamw_pkg::B1_Q32;
			b2p_q     <= adamw_pkg::B2_Q32;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 7'd0 : cnt_q + 7'd1;
			// sweep the moment tables after reset
			if (clr_q) begin
				if (clr_cnt_q == LAST_ADDR) clr_q <= 1'b0;
				else clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			// raise on a new result, drop once the held one is taken
			if (state_q == adamw_pkg::ST_WB && wb_go) m_valid_q <= 1'b1;
			else if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					adamw_pkg::REG_LEARNING_RATE: lr_q <= cfg_data;
					adamw_pkg::REG_WEIGHT_DECAY:  wd_q <= cfg_data[15:0];
					adamw_pkg::REG_TRAIN_COUNT:   tc_q <= cfg_data;
					default: ;
				endcase
			end
			// advance the beta powers at epoch end
			if (state_q == adamw_pkg::ST_MULB1 && op_done) b1p_q <= mul_res[31:0];
			if (state_q == adamw_pkg::ST_MULB2 && op_done) b2p_q <= mul_res[31:0];
		end
	end

	// Tables: write back or clear, read at accept
	always_ff @(posedge clk) begin
		if (wb_we) begin
			w_mem[addr_q] <= kind_q ? w_q : {sw_q, 16'd0};
			a_mem[addr_q] <= kind_q ? a_rd_q : sw_q;
		end
		if (clr_q || wb_we) begin
			m_mem[clr_q ? clr_cnt_q : addr_q] <= (clr_q || !kind_q) ? 48'd0 : m_new_q;
			v_mem[clr_q ? clr_cnt_q : addr_q] <= (clr_q || !kind_q) ? 64'd0 : v_new_q;
		end
		if (s_acc) begin
			w_rd_q <= w_mem[in_addr];
			a_rd_q <= a_mem[in_addr];
			m_rd_q <= m_mem[in_addr];
			v_rd_q <= v_mem[in_addr];
		end
	end

	// Shared multiplier: four 32x32 partial products into a rounding accumulator
	always_comb begin
		a_part = cnt_q[1] ? mul_a[63:32] : mul_a[31:0];
		b_part = cnt_q[0] ? mul_b[63:32] : mul_b[31:0];
		case (pk_s1)
			2'd0:    pp_shift = 128'(p_s1);
			2'd3:    pp_shift = 128'(p_s1) << 64;
			default: pp_shift = 128'(p_s1) << 32;
		endcase
		if (mul_s16) mul_res = acc_q[79:16];
		else if (acc_q[127:96] != 32'd0) mul_res = '1;
		else mul_res = acc_q[95:32];
	end

	always_ff @(posedge clk) begin
		if (is_mul && cnt_q < adamw_pkg::MUL_ISSUE) begin
			p_s1  <= 64'(a_part) * 64'(b_part);
			pk_s1 <= cnt_q[1:0];
		end
		if (is_mul) begin
			if (cnt_q == 7'd0) acc_q <= mul_s16 ? (128'd1 << 15) : (128'd1 << 31);
			else if (cnt_q <= adamw_pkg::MUL_ISSUE) acc_q <= acc_q + pp_shift;
		end
	end

	// Shared shift-subtract unit: restoring division and square root
	always_comb begin
		if (is_sqrt) begin
			shv = {rem_q, dq_q[63:62]};
			opv = {16'd0, root_q, 2'b01};
		end else begin
			shv = {1'b0, rem_q, dq_q[63]};
			opv = {2'b00, d_q};
		end
		dif   = {1'b0, shv} - {1'b0, opv};
		ge    = !dif[66];
		div_q = dsat_q ? '1 : dq_q;
	end

	always_ff @(posedge clk) begin
		if (is_div || is_sqrt) begin
			if (cnt_q == 7'd0) begin
				rem_q  <= is_sqrt ? 64'd0 : div_hi;
				dq_q   <= is_sqrt ? vhat_q : div_lo;
				d_q    <= div_d;
				dsat_q <= !is_sqrt && (div_hi >= div_d);
				root_q <= '0;
			end else if (cnt_q <= (is_sqrt ? adamw_pkg::SQRT_LAST : adamw_pkg::DIV_LAST)) begin
				rem_q <= ge ? dif[63:0] : shv[63:0];
				if (is_sqrt) begin
					dq_q   <= {dq_q[61:0], 2'b00};
					root_q <= {root_q[46:0], ge};
				end else begin
					dq_q <= {dq_q[62:0], ge};
				end
			end
		end
	end

	// Sign handling, moment sums, weight step, decay and rounding
	always_comb begin
		m_old_mag = m_rd_q[47] ? 48'd0 - m_rd_q : m_rd_q;
		g_in_mag  = grad_q[47] ? 48'd0 - grad_q : grad_q;
		wm        = m_new_q[47] ? 48'd0 - m_new_q : m_new_q;
		ms1  = m_rd_q[47] ? 50'd0 - {2'b00, m1_q} : {2'b00, m1_q};
		ms2  = grad_q[47] ? 50'd0 - {2'b00, m2_q} : {2'b00, m2_q};
		msum = ms1 + ms2;
		vsum = 65'(v1_q) + 65'(v2_q);
		wext = {{5{w_rd_q[31]}}, w_rd_q};
		wt   = m_new_q[47] ? wext + {2'b00, step_q} : wext - {2'b00, step_q};
		diff     = {w_q[31], w_q} - {a_rd_q[15], a_rd_q, 16'd0};
		diff_mag = diff[32] ? 33'd0 - diff : diff;
		wext2 = {{3{w_q[31]}}, w_q};
		wt2   = diff[32] ? wext2 + {1'b0, dec_q} : wext2 - {1'b0, dec_q};
		wmag = w_q[31] ? 33'd0 - {1'b0, w_q} : {1'b0, w_q};
		rsum = wmag + 33'd32768;
		rr17 = rsum[32:16];
		if (w_q[31]) rr = 16'd0 - rr17[15:0];
		else if (rr17 > 17'd32767) rr = 16'h7FFF;
		else rr = rr17[15:0];
	end

	// Datapath registers: latch the beat, capture unit results, load the result
	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_q <= s_axis_tuser;
			last_q <= s_axis_tlast;
			idx_q  <= s_axis_tdata[6:0];
			sw_q   <= s_axis_tdata[22:7];
			grad_q <= s_axis_tdata[70:23];
			addr_q <= in_addr;
			inr_q  <= in_idx_ext < 32'(NUM_WEIGHTS);
			sat_q  <= 1'b0;
		end
		if (op_done) begin
			case (state_q)
				adamw_pkg::ST_DIVG:   gm_q    <= div_q[47:0];
				adamw_pkg::ST_MULM1:  m1_q    <= mul_res[47:0];
				adamw_pkg::ST_MULM2:  m2_q    <= mul_res[47:0];
				adamw_pkg::ST_MULGSQ: gsq_q   <= mul_res;
				adamw_pkg::ST_MULV2:  v2_q    <= mul_res;
				adamw_pkg::ST_MULV1:  v1_q    <= mul_res;
				adamw_pkg::ST_DIVMH:  mhat_q  <= div_q;
				adamw_pkg::ST_DIVVH:  vhat_q  <= div_q;
				adamw_pkg::ST_SQRT:   den_q   <= 49'(root_q) + adamw_pkg::EPS_Q40;
				adamw_pkg::ST_DIVRT:  ratio_q <= div_q;
				adamw_pkg::ST_MULSTEP: begin
					step_q <= (mul_res > 64'(adamw_pkg::STEP_CAP)) ? adamw_pkg::STEP_CAP
						: mul_res[34:0];
				end
				adamw_pkg::ST_MULDEC: dec_q <= mul_res[33:0];
				default: ;
			endcase
		end
		// clip the first moment to 48 bits
		if (state_q == adamw_pkg::ST_MSUM) begin
			if (msum[49:47] == 3'b000 || msum[49:47] == 3'b111) begin
				m_new_q <= msum[47:0];
			end else begin
				m_new_q <= msum[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
				sat_q   <= 1'b1;
			end
		end
		// clip the second moment to 64 bits
		if (state_q == adamw_pkg::ST_VSUM) begin
			v_new_q <= vsum[64] ? '1 : vsum[63:0];
			if (vsum[64]) sat_q <= 1'b1;
		end
		// step against the sign of the moment, clip to 32 bits
		if (state_q == adamw_pkg::ST_WSTEP) begin
			if (wt[36:31] == 6'h00 || wt[36:31] == 6'h3F) begin
				w_q <= wt[31:0];
			end else begin
				w_q   <= wt[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				sat_q <= 1'b1;
			end
		end
		// pull toward the anchor, clip to 32 bits
		if (state_q == adamw_pkg::ST_WDEC) begin
			if (wt2[34:31] == 4'h0 || wt2[34:31] == 4'hF) begin
				w_q <= wt2[31:0];
			end else begin
				w_q   <= wt2[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				sat_q <= 1'b1;
			end
		end
		// load the result register
		if (state_q == adamw_pkg::ST_WB && wb_go) begin
			o_idx_q <= idx_q;
			if (!inr_q) begin
				o_wf_q  <= '0;
				o_wr_q  <= '0;
				o_sat_q <= 1'b0;
			end else if (!kind_q) begin
				o_wf_q  <= {sw_q, 16'd0};
				o_wr_q  <= sw_q;
				o_sat_q <= 1'b0;
			end else begin
				o_wf_q  <= w_q;
				o_wr_q  <= rr;
				o_sat_q <= sat_q;
			end
		end
	end

	`ASSERT_NEXT(a_accept_reads, s_acc, state_q == adamw_pkg::ST_READ, "accept without read")
	`ASSERT_CLK(a_clear_blocks, clr_q |-> !s_axis_tready, "beat taken while clearing")
	`ASSERT_CLK(a_result_from_wb, $rose(m_valid_q) |-> $past(state_q) == adamw_pkg::ST_WB, "stray result")
	`ASSERT_NEXT(a_wb_waits, state_q == adamw_pkg::ST_WB && !wb_go, state_q == adamw_pkg::ST_WB, "left wb early")

endmodule

[dv/tb_adamw_weight_update.sv]
// Self-checking testbench for the AdamW weight update core.
`timescale 1ns / 1ps

module tb_adamw_weight_update;

	localparam int N_ENTRIES = 128;
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_GRAD = 1'b1;
	localparam longint M_HI = 64'sd140737488355327;
	localparam longint M_LO = -64'sd140737488355328;
	localparam logic [63:0] ONES64 = '1;
	localparam logic [63:0] ONE_Q32 = 64'd4294967296;

	typedef struct {
		logic        kind;
		logic [6:0]  idx;
		logic [15:0] start_w;
		logic [47:0] grad;
		logic        last;
	} beat_t;

	typedef struct {
		logic [6:0]  idx;
		logic [31:0] w_fix;
		logic [15:0] w_rnd;
		logic        sat;
	} weight_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = adamw_pkg::REG_LEARNING_RATE;
	logic [23:0] cfg_data = '0;

	// Shadow state of the optimizer
	longint      sh_weight[N_ENTRIES];
	longint      sh_anchor[N_ENTRIES];
	longint      sh_m[N_ENTRIES];
	logic [63:0] sh_v[N_ENTRIES];
	logic [63:0] sh_b1pow, sh_b2pow;
	logic [23:0] sh_lr, sh_tc;
	logic [15:0] sh_wd;

	beat_t       pending_beats[$];
	weight_res_t expected_weights[$];
	beat_t       cur_beat;
	bit          loaded[N_ENTRIES];
	int          mismatches = 0;
	int          results_seen = 0;
	int          burst_left = 4;
	int          gap_left = 0;
	int          rx_mode = 0;
	int          rx_cnt = 0;
	logic        long_hold = 1'b0;

	adamw_weight_update i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// round(a*b / 2^32), half up, saturated to 64 bits
	function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b) + 128'h8000_0000;
		if (p[127:96] != 0)
			return ONES64;
		return p[95:32];
	endfunction

	// floor(num * 2^32 / d), saturated to 64 bits
	function automatic logic [63:0] div_q32(logic [63:0] num, logic [63:0] d);
		logic [127:0] n;
		n = 128'(num) << 32;
		if ((num >> 32) >= d)
			return ONES64;
		return 64'(n / 128'(d));
	endfunction

	// floor square root of vhat * 2^32
	function automatic logic [63:0] sqrt_q40(logic [63:0] vhat);
		logic [127:0] n, c;
		logic [63:0] r;
		r = '0;
		n = 128'(vhat) << 32;
		for (int b = 47; b >= 0; b--) begin
			c = 128'(r | (64'd1 << b));
			if (c * c <= n)
				r = c[63:0];
		end
		return r;
	endfunction

	function automatic logic [63:0] mag(longint a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	function automatic longint smul_q32(longint a, logic [63:0] b);
		longint r;
		r = longint'(mul_q32(mag(a), b));
		return a < 0 ? -r : r;
	endfunction

	function automatic longint clip_w(longint w, ref bit sat);
		if (w > 64'sd2147483647) begin
			sat = 1;
			return 64'sd2147483647;
		end
		if (w < -64'sd2147483648) begin
			sat = 1;
			return -64'sd2147483648;
		end
		return w;
	endfunction

	// Apply one beat to the shadow state and return the weight it writes
	function automatic weight_res_t predict_weight(beat_t bt);
		weight_res_t r;
		bit sat;
		longint g, m, w, diff, rr, tc;
		logic [63:0] gm, v1, v2, mhat, vhat, den, ratio, step, dec;
		logic [64:0] vsum;
		int i;
		i = int'(bt.idx);
		sat = 0;
		r.idx = bt.idx;
		if (bt.kind == KIND_LOAD) begin
			sh_anchor[i] = longint'($signed(bt.start_w));
			sh_weight[i] = sh_anchor[i] * 65536;
			sh_m[i] = 0;
			sh_v[i] = '0;
			r.w_fix = sh_weight[i][31:0];
			r.w_rnd = bt.start_w;
			r.sat = 1'b0;
			return r;
		end
		tc = (sh_tc == 0) ? 1 : longint'(sh_tc);
		g = longint'($signed(bt.grad)) / tc;
		m = smul_q32(sh_m[i], 64'(adamw_pkg::B1_Q32)) + smul_q32(g, 64'(adamw_pkg::C1_Q32));
		if (m > M_HI) begin
			m = M_HI;
			sat = 1;
		end
		if (m < M_LO) begin
			m = M_LO;
			sat = 1;
		end
		gm = mag(g);
		v1 = mul_q32(sh_v[i], 64'(adamw_pkg::B2_Q32));
		v2 = mul_q32(mul_q32(gm, gm), 64'(adamw_pkg::C2_Q32));
		vsum = 65'(v1) + 65'(v2);
		if (vsum[64]) begin
			vsum = 65'(ONES64);
			sat = 1;
		end
		mhat = div_q32(mag(m), ONE_Q32 - sh_b1pow);
		vhat = div_q32(vsum[63:0], ONE_Q32 - sh_b2pow);
		den = sqrt_q40(vhat) + 64'(adamw_pkg::EPS_Q40);
		ratio = div_q32(mhat, den);
		step = mul_q32(ratio, 64'(sh_lr));
		if (step > 64'(adamw_pkg::STEP_CAP))
			step = 64'(adamw_pkg::STEP_CAP);
		w = (m < 0) ? sh_weight[i] + longint'(step) : sh_weight[i] - longint'(step);
		w = clip_w(w, sat);
		if (sh_wd != 0) begin
			diff = w - sh_anchor[i] * 65536;
			dec = (mag(diff) * 64'(sh_wd) + 64'd32768) >> 16;
			w = (diff < 0) ? w + longint'(dec) : w - longint'(dec);
			w = clip_w(w, sat);
		end
		sh_weight[i] = w;
		sh_m[i] = m;
		sh_v[i] = vsum[63:0];
		if (bt.last) begin
			sh_b1pow = mul_q32(sh_b1pow, 64'(adamw_pkg::B1_Q32));
			sh_b2pow = mul_q32(sh_b2pow, 64'(adamw_pkg::B2_Q32));
		end
		rr = longint'((mag(w) + 64'd32768) >> 16);
		if (w < 0)
			rr = -rr;
		else if (rr > 32767)
			rr = 32767;
		r.w_fix = w[31:0];
		r.w_rnd = rr[15:0];
		r.sat = sat;
		return r;
	endfunction

	// Driver: offer queued beats in bursts with gaps, record each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_weights.insert(expected_weights.size(), predict_weight(cur_beat));
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					cur_beat = pending_beats.pop_front();
					s_axis_tdata <= {1'b0, cur_beat.grad, cur_beat.start_w, cur_beat.idx};
					s_axis_tuser <= cur_beat.kind;
					s_axis_tlast <= cur_beat.last;
					s_axis_tvalid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 20);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1: gap_left = $urandom_range(1, 8);
							2: gap_left = $urandom_range(1, 120);
							default: gap_left = $urandom_range(100, 500);
						endcase
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall on one of four random patterns, redrawn periodically from rx_cnt
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			rx_cnt++;
			if (rx_cnt % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: m_axis_tready <= !long_hold;
				1: m_axis_tready <= !long_hold && rx_cnt[0];
				2: m_axis_tready <= !long_hold && ($urandom_range(0, 9) < 7);
				default: m_axis_tready <= !long_hold && (rx_cnt % 16 > 12);
			endcase
		end
	end

	// Monitor: compare each result beat with the oldest expected weight
	always @(posedge clk) begin
		weight_res_t exp_w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (expected_weights.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: tdata=%h tuser=%b",
						m_axis_tdata, m_axis_tuser);
			end else begin
				exp_w = expected_weights.pop_front();
				if (m_axis_tdata[6:0] !== exp_w.idx || m_axis_tdata[38:7] !== exp_w.w_fix
					|| m_axis_tdata[54:39] !== exp_w.w_rnd || m_axis_tuser !== exp_w.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"weight mismatch: exp idx=%0d w=%h rnd=%h sat=%b,",
							" got idx=%0d w=%h rnd=%h sat=%b"},
							exp_w.idx, exp_w.w_fix, exp_w.w_rnd, exp_w.sat,
							m_axis_tdata[6:0], m_axis_tdata[38:7], m_axis_tdata[54:39],
							m_axis_tuser);
				end
			end
		end
	end

	// Watchdog: end the run after too many cycles without any beat
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// Long hold-off on the result side so the input backs up
	initial begin
		wait (results_seen >= 40);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		long_hold <= 1'b0;
	end

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			adamw_pkg::REG_LEARNING_RATE: sh_lr = val;
			adamw_pkg::REG_WEIGHT_DECAY: sh_wd = val[15:0];
			adamw_pkg::REG_TRAIN_COUNT: sh_tc = val;
			default: ;
		endcase
	endtask

	task automatic queue_beat(logic kind, int idx, logic [15:0] sw, logic [47:0] grad,
		logic last);
		beat_t bt;
		bt.kind = kind;
		bt.idx = 7'(idx);
		bt.start_w = sw;
		bt.grad = grad;
		bt.last = last;
		if (kind == KIND_LOAD)
			loaded[idx] = 1;
		pending_beats.insert(pending_beats.size(), bt);
	endtask

	function automatic logic [47:0] rand_grad();
		logic [47:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return raw;
			1: return 48'(longint'($signed(raw)) >>> $urandom_range(1, 40));
			2: return '0;
			3: return {raw[47], 47'(raw[46:0] >> 20)};
			default: return 48'(longint'($signed(raw)) >>> $urandom_range(8, 24));
		endcase
	endfunction

	// Mostly gradients on loaded entries, some fresh loads
	task automatic queue_random(int count);
		int idx;
		for (int n = 0; n < count; n++) begin
			idx = $urandom_range(0, N_ENTRIES - 1);
			if (!loaded[idx] || $urandom_range(0, 99) < 20)
				queue_beat(KIND_LOAD, idx, 16'($urandom), rand_grad(), 1'($urandom));
			else
				queue_beat(KIND_GRAD, idx, 16'($urandom), rand_grad(),
					$urandom_range(0, 9) == 0);
		end
	endtask

	// Wait for every beat to be accepted and answered, then let the core settle
	task automatic drain();
		do @(posedge clk);
		while (pending_beats.size() > 0 || s_axis_tvalid || expected_weights.size() > 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < N_ENTRIES; i++) begin
			sh_weight[i] = 0;
			sh_anchor[i] = 0;
			sh_m[i] = 0;
			sh_v[i] = '0;
			loaded[i] = 0;
		end
		sh_b1pow = 64'(adamw_pkg::B1_Q32);
		sh_b2pow = 64'(adamw_pkg::B2_Q32);
		sh_lr = adamw_pkg::LR_RESET;
		sh_wd = adamw_pkg::WD_RESET;
		sh_tc = adamw_pkg::TC_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme loads, extreme gradients, ignored fields, epoch ends
		queue_beat(KIND_LOAD, 0, 16'h8000, 48'hFFFF_FFFF_FFFF, 1'b1);
		queue_beat(KIND_LOAD, 127, 16'h7FFF, '0, 1'b0);
		queue_beat(KIND_LOAD, 1, 16'h0000, 48'h5555_5555_5555, 1'b1);
		queue_beat(KIND_LOAD, 2, 16'hFFFF, '0, 1'b0);
		queue_beat(KIND_LOAD, 85, 16'h5555, 48'hAAAA_AAAA_AAAA, 1'b0);
		queue_beat(KIND_GRAD, 0, 16'h7FFF, 48'h7FFF_FFFF_FFFF, 1'b0);
		queue_beat(KIND_GRAD, 127, 16'h8000, 48'h8000_0000_0000, 1'b0);
		queue_beat(KIND_GRAD, 1, 16'hFFFF, '0, 1'b1);
		queue_beat(KIND_GRAD, 2, '0, 48'h0000_0000_0001, 1'b0);
		queue_beat(KIND_GRAD, 2, '0, 48'hFFFF_FFFF_FFFF, 1'b0);
		queue_beat(KIND_GRAD, 85, 16'hAAAA, 48'h0000_0100_0000, 1'b1);
		queue_beat(KIND_GRAD, 127, '0, 48'h7FFF_FFFF_FFFF, 1'b0);
		queue_beat(KIND_GRAD, 0, '0, 48'h8000_0000_0000, 1'b1);
		queue_beat(KIND_LOAD, 0, 16'h0001, '0, 1'b0);
		queue_beat(KIND_GRAD, 0, '0, 48'hFFF0_0000_0000, 1'b0);
		queue_beat(KIND_GRAD, 1, '0, 48'h000F_FFFF_FFFF, 1'b1);
		queue_random(190);
		drain();

		// Full learning rate: steps reach the cap and weights clip
		write_reg(adamw_pkg::REG_LEARNING_RATE, 24'hFF_FFFF);
		write_reg(adamw_pkg::REG_WEIGHT_DECAY, 24'd0);
		write_reg(adamw_pkg::REG_TRAIN_COUNT, 24'd1);
		queue_random(210);
		drain();

		// Strongest decay, largest divisor
		write_reg(adamw_pkg::REG_LEARNING_RATE, adamw_pkg::LR_RESET);
		write_reg(adamw_pkg::REG_WEIGHT_DECAY, 24'h00_FFFF);
		write_reg(adamw_pkg::REG_TRAIN_COUNT, 24'hFF_FFFF);
		queue_random(210);
		drain();

		// Zero step, weakest decay, zero divisor taken as one
		write_reg(adamw_pkg::REG_LEARNING_RATE, 24'd0);
		write_reg(adamw_pkg::REG_WEIGHT_DECAY, 24'd1);
		write_reg(adamw_pkg::REG_TRAIN_COUNT, 24'd0);
		queue_random(210);
		drain();

		write_reg(adamw_pkg::REG_LEARNING_RATE, 24'($urandom));
		write_reg(adamw_pkg::REG_WEIGHT_DECAY, 24'($urandom_range(0, 4000)));
		write_reg(adamw_pkg::REG_TRAIN_COUNT, 24'($urandom_range(1, 1000)));
		queue_random(215);
		drain();

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
